FILE: rtl/core/amfa_pkg.sv
// Shared types and constants for the acceleration magnitude fall alarm block.
`timescale 1ns / 1ps
`default_nettype none
package amfa_pkg;

    // Item modes
    localparam logic [1:0] MODE_SAMPLE      = 2'd0;
    localparam logic [1:0] MODE_READ_PEAK   = 2'd1;
    localparam logic [1:0] MODE_CLEAR_ALARM = 2'd2;

    // Axis select codes for the shared squarer
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Configuration register map (index taken from paddr[2])
    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned APB_DATA_W   = 32;
    localparam logic        REG_ALARM_THRESHOLD = 1'b0;

    localparam int unsigned MAG_W       = 16;
    localparam int unsigned SUM_W       = 32;
    localparam logic [MAG_W-1:0] THRESHOLD_RESET = 16'd7168;

    // Root iterations: one result bit per step
    localparam int unsigned ROOT_STEPS  = 16;
    localparam int unsigned STEP_CNT_W  = 4;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic             alarm;
        logic [MAG_W-1:0] peak_value;
        logic [MAG_W-1:0] sample_magnitude;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_clr;
        logic       acc_add;
        logic       root_init;
        logic       root_step;
        logic       finish;
    } amfa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic in_is_sample;
        logic out_full;
    } amfa_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/amfa_ctrl.sv
// Sequencing state machine for the acceleration magnitude fall alarm block.
`timescale 1ns / 1ps
`default_nettype none
module amfa_ctrl
    import amfa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         sample_valid,
    output logic              sample_ready,
    input  wire amfa_status_t status,
    output amfa_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_ROOT,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;

    // Hold state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        sample_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.in_is_sample ? ST_SQUARE : ST_FINISH;
                end
            end
            ST_SQUARE:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cnt_reg[1:0];
                cmd.acc_clr = (cnt_reg[1:0] == AXIS_X);
                cmd.acc_add = (cnt_reg[1:0] != AXIS_X);
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == AXIS_Z)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                cmd.acc_add   = 1'b1;
                cmd.root_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(ROOT_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Wait for the output register to drain
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/amfa_dp.sv
// Datapath: squarer, accumulator, iterative square root, peak and alarm state.
`timescale 1ns / 1ps
`default_nettype none
module amfa_dp
    import amfa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sample_t          sample_data,
    input  wire amfa_cmd_t        cmd,
    output amfa_status_t          status,
    input  wire logic             cfg_we,
    input  wire logic [MAG_W-1:0] cfg_wdata,
    output logic [MAG_W-1:0]      threshold,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output result_t               result_data
);

    sample_t             item_reg;
    logic [SUM_W-2:0]    prod_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    root_reg;
    logic [SUM_W-1:0]    bit_reg;
    logic [MAG_W-1:0]    thr_reg;
    logic [MAG_W-1:0]    peak_reg, peak_next;
    logic                alarm_reg, alarm_next;
    logic                valid_reg;
    result_t             out_reg, out_next;

    logic signed [15:0]  axis;
    logic signed [31:0]  square;
    logic [SUM_W:0]      trial;
    logic                fits;
    logic [MAG_W-1:0]    mag;
    logic                is_sample;

    assign status.in_is_sample = (sample_data.mode == MODE_SAMPLE);
    assign status.out_full     = valid_reg && !result_ready;
    assign threshold           = thr_reg;
    assign result_valid        = valid_reg;
    assign result_data         = out_reg;

    // Select one axis for the shared squarer
    always_comb
    begin
        case (cmd.mul_sel)
            AXIS_X:  axis = item_reg.accel_x;
            AXIS_Y:  axis = item_reg.accel_y;
            default: axis = item_reg.accel_z;
        endcase
    end

    assign square = axis * axis;

    // Trial subtraction of one root step
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits  = ({1'b0, rem_reg} >= trial);

    // Result and state update at the end of the transaction
    always_comb
    begin
        is_sample  = (item_reg.mode == MODE_SAMPLE);
        mag        = is_sample ? root_reg[MAG_W-1:0] : '0;
        peak_next  = peak_reg;
        alarm_next = alarm_reg;
        out_next.peak_value = peak_reg;
        case (item_reg.mode)
            MODE_SAMPLE:
            begin
                if (mag > peak_reg)
                begin
                    peak_next = mag;
                end
                if (mag > thr_reg)
                begin
                    alarm_next = 1'b1;
                end
                out_next.peak_value = peak_next;
            end
            MODE_READ_PEAK:
            begin
                peak_next = '0;
            end
            MODE_CLEAR_ALARM:
            begin
                alarm_next = 1'b0;
            end
            default:
            begin
                peak_next  = peak_reg;
            end
        endcase
        out_next.alarm            = alarm_next;
        out_next.sample_magnitude = mag;
    end

    // Capture the item, square and accumulate, iterate the root
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= sample_data;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= square[SUM_W-2:0];
        end
        if (cmd.acc_clr)
        begin
            rem_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            rem_reg <= rem_reg + {1'b0, prod_reg};
        end
        else if (cmd.root_step && fits)
        begin
            rem_reg <= rem_reg - trial[SUM_W-1:0];
        end
        if (cmd.root_init)
        begin
            root_reg <= '0;
            bit_reg  <= SUM_W'(1) << (SUM_W - 2);
        end
        else if (cmd.root_step)
        begin
            root_reg <= fits ? ((root_reg >> 1) + bit_reg) : (root_reg >> 1);
            bit_reg  <= bit_reg >> 2;
        end
        if (cmd.finish)
        begin
            out_reg <= out_next;
        end
    end

    // Hold threshold, peak, alarm and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THRESHOLD_RESET;
            peak_reg  <= '0;
            alarm_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                peak_reg  <= peak_next;
                alarm_reg <= alarm_next;
                valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/accel_magnitude_fall_alarm_core.sv
// Top level of the acceleration magnitude fall alarm block.
//
// Input channel sample_valid/sample_ready/sample_data carries one transaction
// per item: a mode and three signed Q4.11 g axis values. Output channel
// result_valid/result_ready/result_data returns exactly one transaction per
// item: latched alarm, peak magnitude and sample magnitude (unsigned Q5.11).
// An APB port holds the alarm threshold at byte address 0 (reset 3.5 g).
//
// Once accepted, a sample transaction passes its three axes in turn through
// the shared squarer, finishes the sum of squares, runs sixteen steps of
// the bit-per-step square root unit and then updates peak and alarm as the
// result is registered. Read-peak, clear-alarm and undefined-mode
// transactions give a result one cycle after acceptance. The controller
// returns to idle as the result is registered and one item is in work at a
// time, so a new item is accepted only once the previous one is finished.
//
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the following item finishes its work and
// then holds until the output register drains. Reset clears the peak, the
// alarm and the output valid, and restores the threshold to 3.5 g.
`timescale 1ns / 1ps
`default_nettype none
module accel_magnitude_fall_alarm_core
    import amfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_ready,
    input  wire sample_t               sample_data,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    amfa_cmd_t        cmd;
    amfa_status_t     status;
    logic             cfg_we;
    logic [MAG_W-1:0] threshold;

    // Decode register writes and reads
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ALARM_THRESHOLD);
    assign prdata = (paddr[2] == REG_ALARM_THRESHOLD)
                  ? {{(APB_DATA_W - MAG_W){1'b0}}, threshold} : '0;

    amfa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    amfa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_data  (sample_data),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (pwdata[MAG_W-1:0]),
        .threshold    (threshold),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule
`default_nettype wire

FILE: rtl/core/amfa_checker.sv
// Port-level checks for the acceleration magnitude fall alarm block, with bind.
`timescale 1ns / 1ps
`default_nettype none
module amfa_checker
    import amfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    input  wire logic                  sample_ready,
    input  wire sample_t               sample_data,
    input  wire logic                  result_valid,
    input  wire logic                  result_ready,
    input  wire result_t               result_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic [APB_DATA_W-1:0] prdata,
    input  wire logic                  pready
);

    // A stalled result holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // The peak reported never lies below the magnitude reported
    a_peak_covers_mag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_data.sample_magnitude <= result_data.peak_value)
        else $error("peak below sample magnitude");

    // One item in work at a time: no acceptance right after an acceptance
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("input accepted back to back");

    // A write to the threshold reads back on the next cycle
    a_thr_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_ALARM_THRESHOLD)
        ##1 (paddr[2] == REG_ALARM_THRESHOLD)
        |-> prdata == {{(APB_DATA_W - MAG_W){1'b0}}, $past(pwdata[MAG_W-1:0])})
        else $error("threshold readback mismatch");

endmodule

bind accel_magnitude_fall_alarm_core amfa_checker u_amfa_checker (.*);
`default_nettype wire
